// File: rtl/core/smo_pkg.sv
package smo_pkg;

  // Stack capacity; the entry count width follows from it
  localparam int unsigned DEPTH   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

  // Request codes; code three is a no-op
  typedef enum logic [1:0] {
    REQ_PUSH    = 2'd0,
    REQ_POP     = 2'd1,
    REQ_DEL_MID = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               req_type;
    logic signed [DATA_W-1:0] push_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic signed [DATA_W-1:0] middle_value;
    logic [COUNT_W-1:0]       entry_count;
    logic [1:0]               status;
  } out_word_t;

  // Per-cycle command broadcast along one chain of cells
  typedef struct packed {
    logic push;  // shift towards the tail, head takes the front word
    logic pop;   // shift towards the head
    logic wr;    // overwrite the cell at the write index
  } cell_ctrl_t;

endpackage

// File: rtl/core/smo_cell.sv
module smo_cell (
  input  logic                        clk_i,
  input  smo_pkg::cell_ctrl_t         ctrl_i,
  input  logic                        hit_i,
  input  logic [smo_pkg::DATA_W-1:0]  left_i,
  input  logic [smo_pkg::DATA_W-1:0]  right_i,
  input  logic [smo_pkg::DATA_W-1:0]  wdata_i,
  output logic [smo_pkg::DATA_W-1:0]  d_o,
  output logic [smo_pkg::DATA_W-1:0]  q_o
);

  logic [smo_pkg::DATA_W-1:0] val_d, val_q;

  // Select next word: a direct write wins over any shift
  always_comb begin
    if (ctrl_i.wr && hit_i) begin
      val_d = wdata_i;
    end else if (ctrl_i.pop) begin
      val_d = right_i;
    end else if (ctrl_i.push) begin
      val_d = left_i;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign d_o = val_d;
  assign q_o = val_q;

endmodule

// File: rtl/core/smo_chain.sv
module smo_chain #(
  parameter int unsigned N  = 32,
  parameter int unsigned IW = 5
) (
  input  logic                        clk_i,
  input  smo_pkg::cell_ctrl_t         ctrl_i,
  input  logic [smo_pkg::DATA_W-1:0]  front_i,
  input  logic [IW-1:0]               widx_i,
  input  logic [smo_pkg::DATA_W-1:0]  wdata_i,
  output logic [smo_pkg::DATA_W-1:0]  head_d_o,
  output logic [smo_pkg::DATA_W-1:0]  head_q_o
);

  logic [smo_pkg::DATA_W-1:0] q   [N];
  logic [smo_pkg::DATA_W-1:0] d   [N];
  logic [smo_pkg::DATA_W-1:0] lft [N];
  logic [smo_pkg::DATA_W-1:0] rgt [N];
  logic [N-1:0]               hit;

  // Wire each cell to its neighbours; the head takes the front word
  for (genvar i = 0; i < N; i++) begin : g_cell
    assign hit[i] = (widx_i == IW'(i));

    if (i == 0) begin : g_head
      assign lft[i] = front_i;
    end else begin : g_mid
      assign lft[i] = q[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign rgt[i] = q[i];
    end else begin : g_body
      assign rgt[i] = q[i+1];
    end

    smo_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .hit_i   (hit[i]),
      .left_i  (lft[i]),
      .right_i (rgt[i]),
      .wdata_i (wdata_i),
      .d_o     (d[i]),
      .q_o     (q[i])
    );
  end

  assign head_d_o = d[0];
  assign head_q_o = q[0];

endmodule

// File: rtl/core/stack_with_middle_ops.sv
// Channel  Direction  Signals                         Word
// in       input      in_valid_i / in_ready_o         in_word_t  (req_type, push_value)
// out      output     out_valid_o / out_ready_i       out_word_t (removed, middle, count, status)
//
// One request per cycle unless stalled; its result is in the output register on the next cycle.
// Entries live in three chains of cells: the lower half with the middle entry at its
// head, the upper half top-first, and the upper half bottom-first. Every operation is
// at most one shift and one indexed write per chain, so all reads come from chain heads.
// Reset clears the entry count and the output valid; the cells themselves need none.
// A request is taken while the output register is empty or being drained.
module stack_with_middle_ops (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  smo_pkg::in_word_t    in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output smo_pkg::out_word_t   out_word_o
);

  localparam int unsigned DEPTH = smo_pkg::DEPTH;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned LD  = DEPTH - DEPTH / 2;
  localparam int unsigned UD  = DEPTH / 2;
  localparam int unsigned LIW = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned UIW = (UD > 1) ? $clog2(UD) : 1;

  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  logic [CW-1:0] cnt_d, cnt_q;
  logic [CW-2:0] half, half_m1;
  logic          odd, empty, full, fire;

  smo_pkg::cell_ctrl_t         lc, fc, rc;
  logic [smo_pkg::DATA_W-1:0]  lfront, ffront, rfront;
  logic [smo_pkg::DATA_W-1:0]  lwdata, fwdata, rwdata;
  logic [UIW-1:0]              fwidx, rwidx;
  logic [smo_pkg::DATA_W-1:0]  l_head_d, l_head_q, f_head_d, f_head_q, r_head_d, r_head_q;
  logic [smo_pkg::DATA_W-1:0]  removed;
  logic [1:0]                  status;

  smo_pkg::out_word_t out_d, out_q;
  logic               out_vld_q;

  assign half    = cnt_q[CW-1:1];
  assign half_m1 = half - 1'b1;
  assign odd     = cnt_q[0];
  assign empty   = (cnt_q == '0);
  assign full    = (cnt_q == FULL_CNT);

  assign in_ready_o = !out_vld_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  // Decode the request into per-chain commands and keep the halves balanced
  always_comb begin
    cnt_d   = cnt_q;
    lc      = '0;
    fc      = '0;
    rc      = '0;
    lfront  = in_word_i.push_value;
    ffront  = l_head_q;
    rfront  = in_word_i.push_value;
    lwdata  = f_head_q;
    fwdata  = in_word_i.push_value;
    rwdata  = l_head_q;
    fwidx   = half[UIW-1:0];
    rwidx   = half_m1[UIW-1:0];
    removed = '0;
    status  = smo_pkg::STAT_OK;

    if (fire) begin
      case (in_word_i.req_type)
        smo_pkg::REQ_PUSH: begin
          if (full) begin
            status = smo_pkg::STAT_FULL;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (empty) begin
              lc.push = 1'b1;
            end else if (odd) begin
              // grow the upper half at its top
              rc.push = 1'b1;
              fc.wr   = 1'b1;
              fwidx   = half[UIW-1:0];
            end else begin
              // hand the upper bottom down to become the new middle
              lc.push = 1'b1;
              lfront  = f_head_q;
              fc.pop  = 1'b1;
              fc.wr   = 1'b1;
              fwidx   = half_m1[UIW-1:0];
              rc.push = 1'b1;
            end
          end
        end
        smo_pkg::REQ_POP: begin
          if (empty) begin
            status = smo_pkg::STAT_EMPTY;
          end else begin
            cnt_d = cnt_q - 1'b1;
            if (cnt_q == ONE_CNT) begin
              removed = l_head_q;
              lc.pop  = 1'b1;
            end else if (odd) begin
              // drop the top and lift the old middle into the upper half
              removed = r_head_q;
              lc.pop  = 1'b1;
              fc.push = 1'b1;
              rc.pop  = 1'b1;
              rc.wr   = 1'b1;
              rwidx   = half_m1[UIW-1:0];
            end else begin
              removed = r_head_q;
              rc.pop  = 1'b1;
            end
          end
        end
        smo_pkg::REQ_DEL_MID: begin
          if (empty) begin
            status = smo_pkg::STAT_EMPTY;
          end else begin
            cnt_d   = cnt_q - 1'b1;
            removed = l_head_q;
            if (odd) begin
              lc.pop = 1'b1;
            end else begin
              // the upper bottom closes the gap
              lc.wr  = 1'b1;
              fc.pop = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  smo_chain #(.N(LD), .IW(LIW)) u_lower (
    .clk_i    (clk_i),
    .ctrl_i   (lc),
    .front_i  (lfront),
    .widx_i   ('0),
    .wdata_i  (lwdata),
    .head_d_o (l_head_d),
    .head_q_o (l_head_q)
  );

  smo_chain #(.N(UD), .IW(UIW)) u_upper_fwd (
    .clk_i    (clk_i),
    .ctrl_i   (fc),
    .front_i  (ffront),
    .widx_i   (fwidx),
    .wdata_i  (fwdata),
    .head_d_o (f_head_d),
    .head_q_o (f_head_q)
  );

  smo_chain #(.N(UD), .IW(UIW)) u_upper_rev (
    .clk_i    (clk_i),
    .ctrl_i   (rc),
    .front_i  (rfront),
    .widx_i   (rwidx),
    .wdata_i  (rwdata),
    .head_d_o (r_head_d),
    .head_q_o (r_head_q)
  );

  // Form the result word from the post-step middle
  always_comb begin
    out_d.removed_value = removed;
    out_d.middle_value  = (cnt_d == '0) ? '0 : l_head_d;
    out_d.entry_count   = smo_pkg::COUNT_W'(cnt_d);
    out_d.status        = status;
  end

  // Hold the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // Upper-half head lookahead is unused by the decode
  logic unused_heads;
  assign unused_heads = ^{f_head_d, r_head_d};

endmodule

// File: tb/stack_with_middle_ops_tb.sv
module stack_with_middle_ops_tb;

  localparam int unsigned DEPTH = smo_pkg::DEPTH;
  // Request code three carries no operation
  localparam logic [1:0] REQ_NOP = 2'd3;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  smo_pkg::in_word_t  in_word_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  smo_pkg::out_word_t out_word_o;

  stack_with_middle_ops u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Request words waiting to be offered, and step reports still owed by the block
  smo_pkg::in_word_t  request_q[$];
  smo_pkg::out_word_t step_reports_q[$];

  // Shadow stack, bottom entry at index zero
  logic signed [smo_pkg::DATA_W-1:0] shadow_stack[DEPTH];
  int shadow_fill = 0;

  int   errors       = 0;
  int   accepted_cnt = 0;
  logic in_fire      = 1'b0;

  // Generator bookkeeping: approximate fill level of the stimulus so far
  int gen_fill   = 0;
  int random_cnt = 0;

  // Apply one request to the shadow stack and return the report it yields
  function automatic smo_pkg::out_word_t apply_request(smo_pkg::in_word_t req);
    smo_pkg::out_word_t rep;
    int                 mid;
    rep        = '0;
    rep.status = smo_pkg::STAT_OK;
    case (req.req_type)
      smo_pkg::REQ_PUSH: begin
        if (shadow_fill >= DEPTH) begin
          rep.status = smo_pkg::STAT_FULL;
        end else begin
          shadow_stack[shadow_fill] = req.push_value;
          shadow_fill++;
        end
      end
      smo_pkg::REQ_POP: begin
        if (shadow_fill == 0) begin
          rep.status = smo_pkg::STAT_EMPTY;
        end else begin
          shadow_fill--;
          rep.removed_value = shadow_stack[shadow_fill];
        end
      end
      smo_pkg::REQ_DEL_MID: begin
        if (shadow_fill == 0) begin
          rep.status = smo_pkg::STAT_EMPTY;
        end else begin
          mid = (shadow_fill - 1) / 2;
          rep.removed_value = shadow_stack[mid];
          // close up the entries above the removed one
          for (int i = mid; i + 1 < shadow_fill; i++) shadow_stack[i] = shadow_stack[i + 1];
          shadow_fill--;
        end
      end
      default: ;
    endcase
    if (shadow_fill != 0) rep.middle_value = shadow_stack[(shadow_fill - 1) / 2];
    rep.entry_count = smo_pkg::COUNT_W'(shadow_fill);
    return rep;
  endfunction

  task automatic check_field(string name, logic [smo_pkg::DATA_W-1:0] want,
                             logic [smo_pkg::DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  function automatic logic [smo_pkg::DATA_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_request(logic [1:0] op, logic [smo_pkg::DATA_W-1:0] v);
    smo_pkg::in_word_t w;
    w.req_type   = op;
    w.push_value = v;
    request_q.push_back(w);
    if (op == smo_pkg::REQ_PUSH && gen_fill < DEPTH) gen_fill++;
    if ((op == smo_pkg::REQ_POP || op == smo_pkg::REQ_DEL_MID) && gen_fill > 0) gen_fill--;
  endtask

  function automatic logic [1:0] removal_op();
    return $urandom_range(0, 1) ? smo_pkg::REQ_POP : smo_pkg::REQ_DEL_MID;
  endfunction

  // Fill to the brim and beyond, drain to empty and beyond, or wander with a chosen push bias
  task automatic run_phase(int kind);
    int len;
    int push_pct;
    int r;
    case (kind)
      0: begin
        while (gen_fill < DEPTH) begin
          add_request(smo_pkg::REQ_PUSH, rand_value());
          random_cnt++;
        end
        len = $urandom_range(1, 4);
        repeat (len) begin
          add_request(smo_pkg::REQ_PUSH, rand_value());
          random_cnt++;
        end
      end
      1: begin
        while (gen_fill > 0) begin
          add_request(removal_op(), $urandom());
          random_cnt++;
        end
        len = $urandom_range(1, 3);
        repeat (len) begin
          add_request(removal_op(), $urandom());
          random_cnt++;
        end
      end
      default: begin
        len      = $urandom_range(20, 60);
        push_pct = 25 * $urandom_range(1, 3);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 4) add_request(REQ_NOP, $urandom());
          else if (r < 4 + push_pct) add_request(smo_pkg::REQ_PUSH, rand_value());
          else add_request(removal_op(), $urandom());
          random_cnt++;
        end
      end
    endcase
  endtask

  // Sample both channels: predict on each accepted request, check each accepted report
  always @(posedge clk_i) begin : monitor
    smo_pkg::out_word_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        step_reports_q.push_back(apply_request(in_word_i));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (step_reports_q.size() == 0) begin
          $display("%0t: unexpected word, expected none actual %h", $time, out_word_o);
          errors++;
        end else begin
          want = step_reports_q.pop_front();
          check_field("removed_value", want.removed_value, out_word_o.removed_value);
          check_field("middle_value", want.middle_value, out_word_o.middle_value);
          check_field("entry_count", smo_pkg::DATA_W'(want.entry_count),
                      smo_pkg::DATA_W'(out_word_o.entry_count));
          check_field("status", smo_pkg::DATA_W'(want.status),
                      smo_pkg::DATA_W'(out_word_o.status));
        end
      end
    end
  end

  // Offer request words in bursts separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() > 0) begin
        in_word_i  <= request_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          // now and then a long burst with no gap after it
          if ($urandom_range(0, 3) == 0) begin
            burst_left = $urandom_range(30, 60);
            gap_left   = 0;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = $urandom_range(0, 6);
          end
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Drain reports on a stall pattern of its own, with one long hold-off
  int  mode       = 0;
  int  mode_left  = 0;
  int  hold_left  = 0;
  bit  hold_done  = 1'b0;
  int  rx_cycle   = 0;

  always @(negedge clk_i) begin
    rx_cycle++;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && accepted_cnt >= 200) begin
      // hold off long enough for the block to back up into its input
      hold_done = 1'b1;
      hold_left = 150;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 9) < 7);
        2:       out_ready_i <= (rx_cycle % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  initial begin
    // Directed: empty-stack requests, field extremes, middle removal at small sizes
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(smo_pkg::REQ_DEL_MID, 32'hFFFF_FFFF);
    add_request(REQ_NOP, 32'h0);
    add_request(smo_pkg::REQ_PUSH, 32'h7FFF_FFFF);
    add_request(smo_pkg::REQ_DEL_MID, 32'h0);
    add_request(smo_pkg::REQ_PUSH, 32'h8000_0000);
    add_request(smo_pkg::REQ_PUSH, 32'hFFFF_FFFF);
    add_request(smo_pkg::REQ_PUSH, 32'h0);
    add_request(REQ_NOP, 32'hFFFF_FFFF);
    add_request(smo_pkg::REQ_DEL_MID, 32'h0);
    add_request(smo_pkg::REQ_PUSH, 32'h5555_5555);
    add_request(smo_pkg::REQ_PUSH, 32'hAAAA_AAAA);
    add_request(smo_pkg::REQ_DEL_MID, 32'h0);
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(smo_pkg::REQ_PUSH, 32'h1);
    add_request(smo_pkg::REQ_PUSH, 32'h2);
    add_request(smo_pkg::REQ_DEL_MID, 32'h0);
    add_request(smo_pkg::REQ_POP, 32'h0);
    add_request(REQ_NOP, 32'h0);

    // Random: make sure full and empty are both reached, then mix freely
    run_phase(0);
    run_phase(1);
    while (random_cnt < 550) run_phase($urandom_range(0, 5));

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || in_valid_i || step_reports_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
